### design/bsl_pkg.sv
// shared types and constants for the boot-loader frame receiver
package bsl_pkg;

	localparam logic [7:0] FRAME_HEADER     = 8'h80;
	localparam logic [7:0] MAX_LENGTH_RESET = 8'd250;
	localparam int         QUEUE_DEPTH      = 2;
	localparam int         QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int         QCNT_W           = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_HEADER = 3'd1,
		ST_ZERO_LEN   = 3'd2,
		ST_BAD_CHECK  = 3'd3,
		ST_TOO_LONG   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_START,
		OP_FOLD,
		OP_PASS,
		OP_CK_LO,
		OP_CK_HI,
		OP_STATUS
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       fold;
		logic       odd;
		logic [7:0] data;
		status_t    status;
	} cmd_t;

endpackage

### design/bsl_if.sv
// item channels of the frame receiver
interface bsl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface bsl_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] payload_byte;
	logic [2:0] frame_status;
	logic       last;

	modport source (output valid, output kind, output payload_byte, output frame_status,
		output last, input ready);
	modport sink (input valid, input kind, input payload_byte, input frame_status,
		input last, output ready);
endinterface

### design/bsl_frame_receiver.sv
// top level of the boot-loader frame receiver
// path: each result passes through the command queue and the output register
// throughput: one byte per cycle while the queue has room; an output stall fills the two-entry
// queue and then holds off the input (in_ch.ready low) while the queue is full
// reset: arst_n clears frame position, queue and output valid; max_length
// returns to 250; the next byte after reset is taken as a header
module bsl_frame_receiver
	import bsl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bsl_in_if.sink     in_ch,
	bsl_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_avail;
	logic pop;
	cmd_t pop_cmd;

	bsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	bsl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.avail    (q_avail),
		.pop      (pop),
		.pop_cmd  (pop_cmd)
	);

	bsl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (q_avail),
		.cmd    (pop_cmd),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

### design/bsl_front.sv
// front end: tracks frame position and classifies each byte into a command
module bsl_front
	import bsl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bsl_in_if.sink     in_ch,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [8:0] pos_q, pos_d;
	logic [7:0] len_q, len_d;
	logic       hdr_ok_q, hdr_ok_d;
	logic       ck_low_q, ck_low_d;
	logic [7:0] max_len_q;
	logic [8:0] len_end;
	logic [8:0] sum_end;
	logic [7:0] b;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;
	assign b           = in_ch.rx_byte;
	assign len_end     = {1'b0, len_q} + 9'd4;
	assign sum_end     = len_end - {8'd0, len_q[0]};

	always_comb begin
		push_cmd.op     = OP_FOLD;
		push_cmd.fold   = 1'b0;
		push_cmd.odd    = 1'b0;
		push_cmd.data   = b;
		push_cmd.status = ST_OK;
		pos_d           = pos_q;
		len_d           = len_q;
		hdr_ok_d        = hdr_ok_q;
		ck_low_d        = ck_low_q;
		if (pos_q == 9'd0) begin
			push_cmd.op = OP_START;
			hdr_ok_d    = (b == FRAME_HEADER);
			ck_low_d    = 1'b0;
			pos_d       = 9'd1;
		end else if (pos_q == 9'd1) begin
			push_cmd.odd = 1'b1;
			pos_d        = 9'd2;
		end else if (pos_q == 9'd2) begin
			len_d = b;
			pos_d = 9'd3;
		end else if (pos_q == 9'd3) begin
			push_cmd.odd = 1'b1;
			pos_d        = 9'd0;
			if (!hdr_ok_q) begin
				push_cmd.op     = OP_STATUS;
				push_cmd.status = ST_BAD_HEADER;
			end else if (len_q == 8'd0) begin
				push_cmd.op     = OP_STATUS;
				push_cmd.status = ST_ZERO_LEN;
			end else if (len_q > max_len_q) begin
				push_cmd.op     = OP_STATUS;
				push_cmd.status = ST_TOO_LONG;
			end else begin
				pos_d = 9'd4;
			end
		end else if (pos_q < len_end) begin
			push_cmd.op   = OP_PASS;
			push_cmd.fold = (pos_q < sum_end);
			push_cmd.odd  = pos_q[0];
			pos_d         = pos_q + 9'd1;
		end else if (!ck_low_q) begin
			push_cmd.op = OP_CK_LO;
			ck_low_d    = 1'b1;
			pos_d       = pos_q + 9'd1;
		end else begin
			push_cmd.op = OP_CK_HI;
			ck_low_d    = 1'b0;
			pos_d       = 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			hdr_ok_q <= 1'b0;
			ck_low_q <= 1'b0;
		end else if (push) begin
			pos_q    <= pos_d;
			len_q    <= len_d;
			hdr_ok_q <= hdr_ok_d;
			ck_low_q <= ck_low_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

endmodule

### design/bsl_queue.sv
// short command queue between front and back end
module bsl_queue
	import bsl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic avail,
	input  logic pop,
	output cmd_t pop_cmd
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign avail   = (cnt_q != '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

### design/bsl_back.sv
// back end: checksum accumulation, checksum compare and result register
module bsl_back
	import bsl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       avail,
	input  cmd_t       cmd,
	output logic       pop,
	bsl_out_if.source  out_ch
);

	logic [7:0] xor_even_q;
	logic [7:0] xor_odd_q;
	logic [7:0] held_q;
	logic       out_valid_q;
	logic       out_kind_q;
	logic [7:0] out_byte_q;
	status_t    out_status_q;
	logic       needs_out;
	logic       out_free;
	logic       ck_ok;

	always_comb begin
		unique case (cmd.op) inside
			OP_PASS, OP_CK_HI, OP_STATUS: needs_out = 1'b1;
			default:                      needs_out = 1'b0;
		endcase
	end

	assign out_free = !out_valid_q || out_ch.ready;
	assign pop      = avail && (!needs_out || out_free);
	assign ck_ok    = (held_q == ~xor_even_q) && (cmd.data == ~xor_odd_q);

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (cmd.op) inside
				OP_START: begin
					xor_even_q <= cmd.data;
					xor_odd_q  <= '0;
				end
				OP_FOLD, OP_PASS: begin
					if (cmd.op == OP_FOLD || cmd.fold) begin
						if (cmd.odd) begin
							xor_odd_q <= xor_odd_q ^ cmd.data;
						end else begin
							xor_even_q <= xor_even_q ^ cmd.data;
						end
					end
				end
				OP_CK_LO: begin
					held_q <= cmd.data;
				end
				default: begin
				end
			endcase
		end
		if (pop && needs_out) begin
			out_kind_q   <= (cmd.op != OP_PASS);
			out_byte_q   <= (cmd.op == OP_PASS) ? cmd.data : 8'd0;
			if (cmd.op == OP_CK_HI) begin
				out_status_q <= ck_ok ? ST_OK : ST_BAD_CHECK;
			end else if (cmd.op == OP_STATUS) begin
				out_status_q <= cmd.status;
			end else begin
				out_status_q <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pop && needs_out;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = out_kind_q;
	assign out_ch.payload_byte = out_byte_q;
	assign out_ch.frame_status = out_status_q;
	assign out_ch.last         = out_kind_q;

endmodule

### sim/tb_bsl_frame_receiver.sv
`timescale 1ns / 1ps
// self-checking testbench for the boot-loader frame receiver: directed frames, then random frames
module tb_bsl_frame_receiver;
	import bsl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_BYTES = 200;
	localparam int N_DIR = 27;
	localparam int N_PHASES = 6;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		status_t    frame_status;
		logic       last;
	} rx_result_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		logic       has;
		rx_result_t res;
	} dir_row_t;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CHECK,
		FR_BAD_HEADER,
		FR_ZERO_LEN,
		FR_TOO_LONG,
		FR_NOISE
	} frame_kind_t;

	localparam rx_result_t R_NONE       = '{1'b0, 8'h00, ST_OK, 1'b0};
	localparam rx_result_t R_BAD_HEADER = '{1'b1, 8'h00, ST_BAD_HEADER, 1'b1};
	localparam rx_result_t R_ZERO_LEN   = '{1'b1, 8'h00, ST_ZERO_LEN, 1'b1};
	localparam rx_result_t R_TOO_LONG   = '{1'b1, 8'h00, ST_TOO_LONG, 1'b1};
	localparam rx_result_t R_BAD_CHECK  = '{1'b1, 8'h00, ST_BAD_CHECK, 1'b1};

	// bad header, zero length, too long, odd length ok, checksum mismatch
	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{8'hFF, 1'b1, 1'b0, R_NONE},
		'{8'h00, 1'b1, 1'b0, R_NONE},
		'{8'hFF, 1'b1, 1'b0, R_NONE},
		'{8'h00, 1'b1, 1'b1, R_BAD_HEADER},
		'{8'h80, 1'b0, 1'b0, R_NONE},
		'{8'hFF, 1'b0, 1'b0, R_NONE},
		'{8'h00, 1'b0, 1'b0, R_NONE},
		'{8'hFF, 1'b1, 1'b1, R_ZERO_LEN},
		'{8'h80, 1'b0, 1'b0, R_NONE},
		'{8'h5A, 1'b0, 1'b0, R_NONE},
		'{8'hFF, 1'b0, 1'b0, R_NONE},
		'{8'h00, 1'b1, 1'b1, R_TOO_LONG},
		'{8'h80, 1'b0, 1'b0, R_NONE},
		'{8'h11, 1'b0, 1'b0, R_NONE},
		'{8'h01, 1'b0, 1'b0, R_NONE},
		'{8'h01, 1'b0, 1'b0, R_NONE},
		'{8'hAB, 1'b1, 1'b1, '{1'b0, 8'hAB, ST_OK, 1'b0}},
		'{8'h7E, 1'b0, 1'b0, R_NONE},
		'{8'hEF, 1'b0, 1'b0, R_NONE},
		'{8'h80, 1'b0, 1'b0, R_NONE},
		'{8'h22, 1'b0, 1'b0, R_NONE},
		'{8'h02, 1'b0, 1'b0, R_NONE},
		'{8'hFE, 1'b0, 1'b0, R_NONE},
		'{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, '{1'b0, 8'hFF, ST_OK, 1'b0}},
		'{8'h00, 1'b0, 1'b0, R_NONE},
		'{8'h00, 1'b1, 1'b1, R_BAD_CHECK}
	};

	// -1 picks a random max_length
	localparam int PHASE_LIMIT [N_PHASES] = '{255, 1, 0, -1, 250, -1};
	localparam bit PHASE_GAPS [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
	localparam bit PHASE_STALLS [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	bsl_in_if  in_if();
	bsl_out_if out_if();

	bsl_frame_receiver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// frame tracker state
	logic [7:0] p_limit;
	logic [8:0] p_pos;
	logic [7:0] p_len;
	logic       p_hdr_ok;
	logic [7:0] p_sum_lo;
	logic [7:0] p_sum_hi;
	logic [7:0] p_ck_lo;
	logic       p_ck_lo_taken;

	rx_result_t exp_results [$];
	int         err_count = 0;
	int         bytes_sent = 0;
	int         results_seen = 0;
	int         payload_seen = 0;
	int         status_seen [5] = '{0, 0, 0, 0, 0};
	int         cycles = 0;
	int         limit_writes = 0;
	bit         gaps_on = 1'b0;
	bit         stalls_on = 1'b0;
	bit         hold_req = 1'b0;

	task automatic report_error(input string msg);
		if (err_count < 50)
			$display("ERROR %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic logic close_frame(input status_t s, output rx_result_t r);
		r = '{1'b1, 8'h00, s, 1'b1};
		p_pos = 9'd0;
		p_ck_lo_taken = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic track_byte(input logic [7:0] b, output rx_result_t r);
		logic [8:0]  frame_end;
		logic [8:0]  sum_end;
		logic [15:0] want;
		r = R_NONE;
		track_byte = 1'b0;
		frame_end = {1'b0, p_len} + 9'd4;
		sum_end = frame_end - {8'd0, p_len[0]};
		if (p_pos == 9'd0) begin
			p_hdr_ok = (b == FRAME_HEADER);
			p_sum_lo = b;
			p_sum_hi = 8'h00;
			p_ck_lo = 8'h00;
			p_ck_lo_taken = 1'b0;
			p_pos = 9'd1;
		end else if (p_pos == 9'd1) begin
			p_sum_hi = b;
			p_pos = 9'd2;
		end else if (p_pos == 9'd2) begin
			p_len = b;
			p_sum_lo = p_sum_lo ^ b;
			p_pos = 9'd3;
		end else if (p_pos == 9'd3) begin
			p_sum_hi = p_sum_hi ^ b;
			if (!p_hdr_ok)
				track_byte = close_frame(ST_BAD_HEADER, r);
			else if (p_len == 8'd0)
				track_byte = close_frame(ST_ZERO_LEN, r);
			else if (p_len > p_limit)
				track_byte = close_frame(ST_TOO_LONG, r);
			else
				p_pos = 9'd4;
		end else if (p_pos < frame_end) begin
			if (p_pos < sum_end) begin
				if (p_pos[0])
					p_sum_hi = p_sum_hi ^ b;
				else
					p_sum_lo = p_sum_lo ^ b;
			end
			p_pos = p_pos + 9'd1;
			r.payload_byte = b;
			track_byte = 1'b1;
		end else if (!p_ck_lo_taken) begin
			p_ck_lo = b;
			p_ck_lo_taken = 1'b1;
			p_pos = p_pos + 9'd1;
		end else begin
			want = ~{p_sum_hi, p_sum_lo};
			if (p_ck_lo == want[7:0] && b == want[15:8])
				track_byte = close_frame(ST_OK, r);
			else
				track_byte = close_frame(ST_BAD_CHECK, r);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic typed, input logic has,
			input rx_result_t res);
		rx_result_t pr;
		logic       pr_has;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.rx_byte <= b;
		do @(posedge clk); while (!in_if.ready);
		pr_has = track_byte(b, pr);
		if (typed) begin
			pr_has = has;
			pr = res;
		end
		if (pr_has)
			exp_results.push_back(pr);
		bytes_sent++;
	endtask

	task automatic write_limit(input logic [7:0] v);
		in_if.valid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		p_limit = v;
		limit_writes++;
	endtask

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return FR_GOOD;
		if (r < 77)
			return FR_BAD_CHECK;
		if (r < 83)
			return FR_BAD_HEADER;
		if (r < 88)
			return FR_ZERO_LEN;
		if (r < 94)
			return FR_TOO_LONG;
		return FR_NOISE;
	endfunction

	task automatic send_frame(input frame_kind_t kind, input bit full);
		logic [7:0]  fb [$];
		logic [7:0]  len;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [15:0] ck;
		int          top;
		int          i;
		if ((kind == FR_GOOD || kind == FR_BAD_CHECK) && p_limit == 8'd0)
			kind = FR_TOO_LONG;
		if (kind == FR_TOO_LONG && p_limit == 8'd255)
			kind = FR_GOOD;
		case (kind)
			FR_NOISE: begin
				repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
			end
			FR_BAD_HEADER: begin
				lo = 8'($urandom_range(0, 254));
				if (lo >= FRAME_HEADER)
					lo = lo + 8'd1;
				fb.push_back(lo);
				repeat (3) fb.push_back(8'($urandom));
			end
			FR_ZERO_LEN: begin
				fb.push_back(FRAME_HEADER);
				fb.push_back(8'($urandom));
				fb.push_back(8'h00);
				fb.push_back(8'($urandom));
			end
			FR_TOO_LONG: begin
				fb.push_back(FRAME_HEADER);
				fb.push_back(8'($urandom));
				fb.push_back(8'($urandom_range(int'(p_limit) + 1, 255)));
				fb.push_back(8'($urandom));
			end
			default: begin
				top = (p_limit < 8'd12) ? int'(p_limit) : 12;
				if (full)
					len = p_limit;
				else if ($urandom_range(0, 29) == 0)
					len = 8'($urandom_range(1, int'(p_limit)));
				else
					len = 8'($urandom_range(1, top));
				fb.push_back(FRAME_HEADER);
				fb.push_back(8'($urandom));
				fb.push_back(len);
				fb.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : len);
				repeat (len) fb.push_back(8'($urandom));
				lo = 8'h00;
				hi = 8'h00;
				for (i = 0; i < int'(len) + 4 - int'(len[0]); i++) begin
					if (i % 2 == 0)
						lo = lo ^ fb[i];
					else
						hi = hi ^ fb[i];
				end
				ck = ~{hi, lo};
				if (kind == FR_BAD_CHECK)
					ck = ck ^ (16'd1 << $urandom_range(0, 15));
				fb.push_back(ck[7:0]);
				fb.push_back(ck[15:8]);
			end
		endcase
		foreach (fb[j])
			send_byte(fb[j], 1'b0, 1'b0, R_NONE);
	endtask

	// receiver side
	initial begin
		out_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_if.ready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				out_if.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_if.ready <= 1'b1;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rx_result_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			results_seen++;
			if (exp_results.size() == 0) begin
				report_error($sformatf("unexpected item: kind %0d byte %02h status %0d last %0d",
					out_if.kind, out_if.payload_byte, out_if.frame_status, out_if.last));
			end else begin
				want = exp_results.pop_front();
				if (out_if.kind !== want.kind)
					report_error($sformatf("kind %0d, want %0d", out_if.kind, want.kind));
				if (out_if.payload_byte !== want.payload_byte)
					report_error($sformatf("payload_byte %02h, want %02h",
						out_if.payload_byte, want.payload_byte));
				if (out_if.frame_status !== want.frame_status)
					report_error($sformatf("frame_status %0d, want %0d",
						out_if.frame_status, want.frame_status));
				if (out_if.last !== want.last)
					report_error($sformatf("last %0d, want %0d", out_if.last, want.last));
				if (want.kind)
					status_seen[want.frame_status]++;
				else
					payload_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still expected",
				cycles, exp_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		dir_row_t row;
		int       phase;
		int       phase_base;
		int       lim;
		bit       first;
		arst_n <= 1'b0;
		in_if.valid <= 1'b0;
		in_if.rx_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'h00;
		p_limit = MAX_LENGTH_RESET;
		p_pos = 9'd0;
		p_len = 8'd0;
		p_hdr_ok = 1'b0;
		p_sum_lo = 8'h00;
		p_sum_hi = 8'h00;
		p_ck_lo = 8'h00;
		p_ck_lo_taken = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gaps_on = 1'b1;
		stalls_on = 1'b1;
		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_TAB[i];
			send_byte(row.rx, row.typed, row.has, row.res);
		end

		for (phase = 0; phase < N_PHASES; phase++) begin
			lim = (PHASE_LIMIT[phase] < 0) ? $urandom_range(2, 254) : PHASE_LIMIT[phase];
			write_limit(8'(lim));
			gaps_on = PHASE_GAPS[phase];
			stalls_on = PHASE_STALLS[phase];
			// long receiver hold while a max-length frame streams in
			if (phase == 0)
				hold_req = 1'b1;
			phase_base = bytes_sent;
			first = 1'b1;
			while (bytes_sent - phase_base < PHASE_BYTES) begin
				send_frame(first ? FR_GOOD : pick_kind(), first);
				first = 1'b0;
			end
		end

		in_if.valid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d bytes, %0d items out (%0d payload), %0d max_length writes",
			bytes_sent, results_seen, payload_seen, limit_writes);
		$display("frame endings: ok %0d, bad header %0d, zero length %0d, bad checksum %0d, too long %0d",
			status_seen[ST_OK], status_seen[ST_BAD_HEADER], status_seen[ST_ZERO_LEN],
			status_seen[ST_BAD_CHECK], status_seen[ST_TOO_LONG]);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
